/* sv/dtt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the two-way ranging time-of-flight block.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RESULT_DELAY = 2'd0,
    CFG_TX_ANT_DELAY = 2'd1,
    CFG_MM_PER_TICK  = 2'd2
  } cfg_idx_t;

  localparam logic [39:0] RESULT_DELAY_RST = 40'd131072000;
  localparam logic [15:0] TX_ANT_DELAY_RST = 16'd16575;
  localparam logic [23:0] MM_PER_TICK_RST  = 24'd307479;

  // Queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Quotient bits produced by the divider pipeline
  localparam int DIV_STEPS = 40;

  // Largest Q4 magnitude carried into the distance product
  localparam logic [39:0] MAG_CAP = 40'h80_0000_0000;

  typedef struct packed {
    logic [31:0] tag_poll_tx;
    logic [31:0] tag_resp_rx;
    logic [31:0] tag_final_tx;
    logic [39:0] anchor_poll_rx;
    logic [39:0] anchor_resp_tx;
    logic [39:0] anchor_final_rx;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] flight_time_q4;
    logic signed [31:0] distance_mm;
    logic [31:0]        sched_tx_time;
    logic [31:0]        result_tx_stamp;
    logic               zero_divisor;
    logic               saturated;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic [33:0] den;
    logic        zero;
    logic [31:0] txt;
    logic [31:0] stamp;
  } work_t;

endpackage

/* sv/dtt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_front
// Forms the four intervals, products, divisor and transmit fields.
// ----------------------------------------------------------------------------
module dtt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  dtt_pkg::in_item_t item,
  input  logic [39:0]       result_delay,
  input  logic [15:0]       tx_ant_delay,
  output logic [1:0]        inflight,
  output logic              work_push,
  output dtt_pkg::work_t    work
);

  logic        v1_r, v2_r, v3_r;
  logic [31:0] ra_r, rb_r, da_r, db_r, txt1_r;
  logic [63:0] p1_r, p2_r;
  logic [33:0] den2_r;
  logic [31:0] txt2_r, stamp2_r;
  logic [40:0] txt_sum;
  dtt_pkg::work_t work_r;

  assign txt_sum = {1'b0, item.anchor_final_rx} + {1'b0, result_delay};

  // Valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: intervals modulo 2^32, transmit time
  always_ff @(posedge clk) begin
    ra_r   <= item.tag_resp_rx - item.tag_poll_tx;
    rb_r   <= item.anchor_final_rx[31:0] - item.anchor_resp_tx[31:0];
    da_r   <= item.tag_final_tx - item.tag_resp_rx;
    db_r   <= item.anchor_resp_tx[31:0] - item.anchor_poll_rx[31:0];
    txt1_r <= txt_sum[39:8];
  end

  // Stage 2: products, divisor, predicted stamp
  always_ff @(posedge clk) begin
    p1_r     <= 64'(ra_r) * 64'(rb_r);
    p2_r     <= 64'(da_r) * 64'(db_r);
    den2_r   <= 34'(ra_r) + 34'(rb_r) + 34'(da_r) + 34'(db_r);
    txt2_r   <= txt1_r;
    stamp2_r <= {txt1_r[23:1], 1'b0, 8'h00} + {16'h0000, tx_ant_delay};
  end

  // Stage 3: sign and magnitude of the numerator
  always_ff @(posedge clk) begin
    work_r.neg   <= p1_r < p2_r;
    work_r.mag   <= (p1_r < p2_r) ? (p2_r - p1_r) : (p1_r - p2_r);
    work_r.den   <= den2_r;
    work_r.zero  <= den2_r == 34'd0;
    work_r.txt   <= txt2_r;
    work_r.stamp <= stamp2_r;
  end

  assign inflight  = 2'({1'b0, v1_r} + {1'b0, v2_r} + {1'b0, v3_r});
  assign work_push = v3_r;
  assign work      = work_r;

endmodule

/* sv/dtt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module dtt_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  dtt_pkg::work_t             push_data,
  input  logic                       pop,
  output dtt_pkg::work_t             pop_data,
  output logic                       empty,
  output logic [dtt_pkg::QCNT_W-1:0] count
);

  dtt_pkg::work_t slot_r [dtt_pkg::QDEPTH];
  logic [dtt_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [dtt_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign pop_data = slot_r[rd_r];
  assign empty    = cnt_r == '0;
  assign count    = cnt_r;

endmodule

/* sv/dtt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_back
// Pipelined restoring divider, distance product, clamping, result register.
// ----------------------------------------------------------------------------
module dtt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  dtt_pkg::work_t     q_data,
  output logic               q_pop,
  input  logic [23:0]        mm_per_tick,
  input  logic               out_pop,
  output logic               out_empty,
  output dtt_pkg::out_item_t out_item
);

  typedef struct packed {
    logic [33:0] rem;
    logic [39:0] lo;
    logic [39:0] q;
    logic        over;
    logic [33:0] den;
    logic        neg;
    logic        zero;
    logic [31:0] txt;
    logic [31:0] stamp;
  } div_t;

  // One quotient bit per stage
  function automatic div_t div_step(input div_t d);
    div_t        r;
    logic [34:0] r2;
    logic        ge;
    r    = d;
    r2   = {d.rem, d.lo[39]};
    ge   = r2 >= {1'b0, d.den};
    r.rem = ge ? 34'(r2 - {1'b0, d.den}) : r2[33:0];
    r.q   = {d.q[38:0], ge};
    r.lo  = {d.lo[38:0], 1'b0};
    return r;
  endfunction

  // Clamp a magnitude into a signed 32-bit field; msb of result is the flag
  function automatic logic [32:0] clamp32(input logic [43:0] mag, input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (mag > 44'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else                       r = {1'b0, 32'h0 - mag[31:0]};
    end else begin
      if (mag > 44'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                       r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  logic ben;
  div_t div_r   [dtt_pkg::DIV_STEPS+1];
  div_t div_nxt [dtt_pkg::DIV_STEPS+1];
  logic [dtt_pkg::DIV_STEPS:0] dv_r;

  logic        m1_v_r, m2_v_r, out_v_r;
  logic [39:0] m1_q4_r, m2_q4_r;
  logic        m1_neg_r, m1_zero_r, m2_neg_r, m2_zero_r;
  logic [31:0] m1_txt_r, m1_stamp_r, m2_txt_r, m2_stamp_r;
  logic [55:0] m2_plo_r;
  logic [31:0] m2_phi_r;
  logic [63:0] dprod;
  logic [32:0] tof_c, dist_c;
  dtt_pkg::out_item_t out_r, out_nxt;
  div_t last;

  // Whole back pipeline advances when the result register can take a request
  assign ben   = !out_v_r || out_pop;
  assign q_pop = ben && !q_empty;

  // Entry stage: initial remainder and quotient overflow check
  always_comb begin
    div_nxt[0].rem   = {6'd0, q_data.mag[63:36]};
    div_nxt[0].lo    = {q_data.mag[35:0], 4'h0};
    div_nxt[0].q     = '0;
    div_nxt[0].over  = {6'd0, q_data.mag[63:36]} >= q_data.den;
    div_nxt[0].den   = q_data.den;
    div_nxt[0].neg   = q_data.neg;
    div_nxt[0].zero  = q_data.zero;
    div_nxt[0].txt   = q_data.txt;
    div_nxt[0].stamp = q_data.stamp;
    for (int i = 0; i < dtt_pkg::DIV_STEPS; i++) begin
      div_nxt[i+1] = div_step(div_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      for (int i = 0; i <= dtt_pkg::DIV_STEPS; i++) begin
        div_r[i] <= div_nxt[i];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r    <= '0;
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (ben) begin
      dv_r    <= {dv_r[dtt_pkg::DIV_STEPS-1:0], !q_empty};
      m1_v_r  <= dv_r[dtt_pkg::DIV_STEPS];
      m2_v_r  <= m1_v_r;
      out_v_r <= m2_v_r;
    end
  end

  assign last = div_r[dtt_pkg::DIV_STEPS];

  // Cap the Q4 magnitude, then split the distance product
  always_ff @(posedge clk) begin
    if (ben) begin
      m1_q4_r    <= (last.over || last.q > dtt_pkg::MAG_CAP) ? dtt_pkg::MAG_CAP : last.q;
      m1_neg_r   <= last.neg;
      m1_zero_r  <= last.zero;
      m1_txt_r   <= last.txt;
      m1_stamp_r <= last.stamp;
      m2_plo_r   <= 56'(m1_q4_r[31:0]) * 56'(mm_per_tick);
      m2_phi_r   <= 32'(m1_q4_r[39:32]) * 32'(mm_per_tick);
      m2_q4_r    <= m1_q4_r;
      m2_neg_r   <= m1_neg_r;
      m2_zero_r  <= m1_zero_r;
      m2_txt_r   <= m1_txt_r;
      m2_stamp_r <= m1_stamp_r;
    end
  end

  // Final sum, clamping and zero-divisor handling
  assign dprod  = {8'h00, m2_plo_r} + {m2_phi_r, 32'h0000_0000};
  assign tof_c  = clamp32({4'h0, m2_q4_r}, m2_neg_r);
  assign dist_c = clamp32(dprod[63:20], m2_neg_r);

  always_comb begin
    out_nxt.sched_tx_time   = m2_txt_r;
    out_nxt.result_tx_stamp = m2_stamp_r;
    out_nxt.zero_divisor    = m2_zero_r;
    if (m2_zero_r) begin
      out_nxt.flight_time_q4 = '0;
      out_nxt.distance_mm    = '0;
      out_nxt.saturated      = 1'b0;
    end else begin
      out_nxt.flight_time_q4 = tof_c[31:0];
      out_nxt.distance_mm    = dist_c[31:0];
      out_nxt.saturated      = tof_c[32] || dist_c[32];
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      out_r <= out_nxt;
    end
  end

  assign out_empty = !out_v_r;
  assign out_item  = out_r;

endmodule

/* sv/ds_twr_time_of_flight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight
// Double-sided two-way ranging time of flight, distance and result timing.
// ----------------------------------------------------------------------------
// Takes one ranging record per cycle while in_full is low and returns one
// result per record, in order. A record passes through the front stages
// (intervals, 32x32 products, numerator sign), the request queue, the
// overflow-check stage, the pipelined divider (one quotient bit per stage)
// and the stages for capping, the split distance product and clamping.
// in_full rises when the queue plus requests still in the front reach eight.
// Configuration is taken every cycle (cfg_ready is always high) and must only
// be written while no request is in flight.
module ds_twr_time_of_flight (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  dtt_pkg::in_item_t  in_item,
  output logic               in_full,
  input  logic               out_pop,
  output dtt_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data
);

  logic [39:0] result_delay_r;
  logic [15:0] tx_ant_delay_r;
  logic [23:0] mm_per_tick_r;
  logic        accept;
  logic [1:0]  inflight;
  logic        work_push, q_pop, q_empty;
  dtt_pkg::work_t work, q_data;
  logic [dtt_pkg::QCNT_W-1:0] q_count;
  logic [dtt_pkg::QCNT_W:0]   occupancy;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_delay_r <= dtt_pkg::RESULT_DELAY_RST;
      tx_ant_delay_r <= dtt_pkg::TX_ANT_DELAY_RST;
      mm_per_tick_r  <= dtt_pkg::MM_PER_TICK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dtt_pkg::CFG_RESULT_DELAY: result_delay_r <= cfg_data;
        dtt_pkg::CFG_TX_ANT_DELAY: tx_ant_delay_r <= cfg_data[15:0];
        dtt_pkg::CFG_MM_PER_TICK:  mm_per_tick_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Admission: reserve queue room for every request still in the front
  assign occupancy = {1'b0, q_count} + (dtt_pkg::QCNT_W+1)'(inflight);
  assign in_full   = occupancy >= (dtt_pkg::QCNT_W+1)'(dtt_pkg::QDEPTH);
  assign accept    = in_push && !in_full;

  dtt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .item         (in_item),
    .result_delay (result_delay_r),
    .tx_ant_delay (tx_ant_delay_r),
    .inflight     (inflight),
    .work_push    (work_push),
    .work         (work)
  );

  dtt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (work_push),
    .push_data (work),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  dtt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .mm_per_tick (mm_per_tick_r),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_item    (out_item)
  );

endmodule
